@@ hw/rtl/riaex_pkg.sv @@
// ----------------------------------------------------------------------------
// riaex_pkg: shared types and constants of the integer ALU execute core
// Opcode and field constants, the ALU operation codes and the control record
// handed from the decoder to the ALU datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package riaex_pkg;

    localparam int DEFAULT_XLEN = 64;
    localparam int DATA_W       = 64;
    localparam int INSN_W       = 32;
    localparam int REG_IDX_W    = 5;

    localparam logic [6:0] OPC_OP_IMM    = 7'h13;
    localparam logic [6:0] OPC_OP        = 7'h33;
    localparam logic [6:0] OPC_OP_IMM_32 = 7'h1B;
    localparam logic [6:0] OPC_OP_32     = 7'h3B;
    localparam logic [6:0] F7_ALT        = 7'h20;
    localparam logic [6:0] F7_ZERO       = 7'h00;

    typedef enum logic [2:0] {
        ALU_ADD  = 3'd0,
        ALU_SLL  = 3'd1,
        ALU_SLT  = 3'd2,
        ALU_SLTU = 3'd3,
        ALU_XOR  = 3'd4,
        ALU_SRL  = 3'd5,
        ALU_OR   = 3'd6,
        ALU_AND  = 3'd7
    } t_alu_op;

    typedef struct packed {
        logic    legal;
        logic    word;
        logic    alt;
        t_alu_op op;
    } t_alu_ctrl;

endpackage

`default_nettype wire

@@ hw/rtl/rv_integer_alu_execute_core.sv @@
// ----------------------------------------------------------------------------
// rv_integer_alu_execute_core: integer ALU execute stage
// Decodes OP, OP-IMM and the word forms and gives the ALU result, the
// destination index, the write enable and the illegal flag.
// ----------------------------------------------------------------------------
//  Channel | Handshake                 | Payload
//  input   | i_in_valid / o_in_ready   | i_instruction, i_rs1_value, i_rs2_value
//  output  | o_out_valid / i_out_ready | o_result_value, o_dest_index,
//          |                           | o_write_enable, o_illegal
//
//  A request passes through one input register, then decode and ALU logic into
//  the result register, which drives the output payload and o_out_valid.
//  One request is accepted every cycle while the output side takes results.
//  A stalled result holds; the input register still fills behind it.
//  Synchronous active-low reset clears both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module rv_integer_alu_execute_core #(
    parameter int XLEN = riaex_pkg::DEFAULT_XLEN
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [riaex_pkg::INSN_W-1:0]       i_instruction,
    input  wire logic [riaex_pkg::DATA_W-1:0]       i_rs1_value,
    input  wire logic [riaex_pkg::DATA_W-1:0]       i_rs2_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [riaex_pkg::DATA_W-1:0]            o_result_value,
    output logic [riaex_pkg::REG_IDX_W-1:0]         o_dest_index,
    output logic                                    o_write_enable,
    output logic                                    o_illegal
);

    logic                              r_in_valid;
    logic                              n_in_valid;
    logic [riaex_pkg::INSN_W-1:0]      r_instruction;
    logic [XLEN-1:0]                   r_rs1;
    logic [XLEN-1:0]                   r_rs2;
    logic                              r_out_valid;
    logic                              n_out_valid;
    logic [XLEN-1:0]                   r_result;
    logic [riaex_pkg::REG_IDX_W-1:0]   r_dest;
    logic                              r_we;
    logic                              r_illegal;

    riaex_pkg::t_alu_ctrl              ctrl;
    logic [XLEN-1:0]                   operand_b;
    logic [XLEN-1:0]                   alu_result;
    logic [riaex_pkg::REG_IDX_W-1:0]   rd;
    logic                              out_free;
    logic                              advance;
    logic                              accept;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign rd         = r_instruction[11:7];

    assign n_in_valid  = accept || (r_in_valid && !advance);
    assign n_out_valid = advance || (r_out_valid && !i_out_ready);

    riaex_decode #(
        .XLEN(XLEN)
    ) u_decode (
        .i_instruction (r_instruction),
        .i_rs2_value   (r_rs2),
        .o_ctrl        (ctrl),
        .o_operand_b   (operand_b)
    );

    riaex_alu #(
        .XLEN(XLEN)
    ) u_alu (
        .i_ctrl      (ctrl),
        .i_operand_a (r_rs1),
        .i_operand_b (operand_b),
        .o_result    (alu_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_instruction <= i_instruction;
            r_rs1         <= i_rs1_value[XLEN-1:0];
            r_rs2         <= i_rs2_value[XLEN-1:0];
        end
        if (advance) begin
            r_result  <= alu_result;
            r_dest    <= rd;
            r_we      <= ctrl.legal && (rd != '0);
            r_illegal <= !ctrl.legal;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = riaex_pkg::DATA_W'(r_result);
    assign o_dest_index   = r_dest;
    assign o_write_enable = r_we;
    assign o_illegal      = r_illegal;

endmodule

`default_nettype wire

@@ hw/rtl/riaex_decode.sv @@
// ----------------------------------------------------------------------------
// riaex_decode: instruction decoder
// Checks opcode and funct fields for legality, selects the operation and
// builds the second operand from rs2 or the sign-extended immediate.
// ----------------------------------------------------------------------------
`default_nettype none

module riaex_decode #(
    parameter int XLEN = riaex_pkg::DEFAULT_XLEN
) (
    input  wire logic [riaex_pkg::INSN_W-1:0] i_instruction,
    input  wire logic [XLEN-1:0]              i_rs2_value,
    output riaex_pkg::t_alu_ctrl              o_ctrl,
    output logic [XLEN-1:0]                   o_operand_b
);

    localparam logic [6:0] ShamtSpill = (XLEN / 32 > 1) ? 7'h01 : 7'h00;
    localparam logic       HasWord    = (XLEN > 32) ? 1'b1 : 1'b0;

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic        reg_form;
    logic        f7_nonzero;
    logic        f7_ok;
    logic        is_full;
    logic        is_word;
    logic        full_legal;
    logic        full_alt;
    logic        word_legal;
    logic        word_alt;
    logic [63:0] imm_ext;

    assign opc        = i_instruction[6:0];
    assign f3         = i_instruction[14:12];
    assign f7         = i_instruction[31:25];
    assign reg_form   = opc[5];
    assign f7_nonzero = (f7 != riaex_pkg::F7_ZERO);
    assign f7_ok      = !reg_form || (f7 == riaex_pkg::F7_ZERO) || (f7 == riaex_pkg::F7_ALT);
    assign is_full    = (opc == riaex_pkg::OPC_OP) || (opc == riaex_pkg::OPC_OP_IMM);
    assign is_word    = HasWord &&
                        ((opc == riaex_pkg::OPC_OP_32) || (opc == riaex_pkg::OPC_OP_IMM_32));
    assign imm_ext    = {{52{i_instruction[31]}}, i_instruction[31:20]};

    always_comb begin
        full_legal = 1'b0;
        full_alt   = 1'b0;
        word_legal = 1'b0;
        word_alt   = 1'b0;
        unique case (f3)
            3'd0: begin
                full_legal = 1'b1;
                full_alt   = reg_form && f7_nonzero;
                word_legal = 1'b1;
                word_alt   = reg_form && f7_nonzero;
            end
            3'd1: begin
                full_legal = ((f7 & ~ShamtSpill) == riaex_pkg::F7_ZERO);
                word_legal = !f7_nonzero;
            end
            3'd5: begin
                full_legal = ((f7 & ~ShamtSpill & ~riaex_pkg::F7_ALT) == riaex_pkg::F7_ZERO);
                full_alt   = ((f7 & ~ShamtSpill) != riaex_pkg::F7_ZERO);
                word_legal = ((f7 & ~riaex_pkg::F7_ALT) == riaex_pkg::F7_ZERO);
                word_alt   = f7_nonzero;
            end
            default: begin
                full_legal = !(reg_form && f7_nonzero);
            end
        endcase
    end

    always_comb begin
        o_ctrl.op    = riaex_pkg::t_alu_op'(f3);
        o_ctrl.word  = is_word;
        o_ctrl.alt   = is_word ? word_alt : full_alt;
        o_ctrl.legal = f7_ok && ((is_full && full_legal) || (is_word && word_legal));
    end

    assign o_operand_b = reg_form ? i_rs2_value : imm_ext[XLEN-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/riaex_alu.sv @@
// ----------------------------------------------------------------------------
// riaex_alu: integer ALU datapath
// Computes the full-width and 32-bit word results for the decoded operation
// and forces zero for an illegal instruction.
// ----------------------------------------------------------------------------
`default_nettype none

module riaex_alu #(
    parameter int XLEN = riaex_pkg::DEFAULT_XLEN
) (
    input  wire riaex_pkg::t_alu_ctrl i_ctrl,
    input  wire logic [XLEN-1:0]      i_operand_a,
    input  wire logic [XLEN-1:0]      i_operand_b,
    output logic [XLEN-1:0]           o_result
);

    localparam int             ShW    = $clog2(XLEN);
    localparam logic [ShW-1:0] ShMask = ShW'(XLEN - 1);

    logic [ShW-1:0]  sh;
    logic [4:0]      wsh;
    logic [31:0]     a32;
    logic [31:0]     b32;
    logic [XLEN-1:0] full_res;
    logic [31:0]     word_res;
    logic [63:0]     word_ext;
    logic            lt_s;
    logic            lt_u;

    assign sh   = i_operand_b[ShW-1:0] & ShMask;
    assign wsh  = i_operand_b[4:0];
    assign a32  = i_operand_a[31:0];
    assign b32  = i_operand_b[31:0];
    assign lt_s = $signed(i_operand_a) < $signed(i_operand_b);
    assign lt_u = i_operand_a < i_operand_b;

    always_comb begin
        case (i_ctrl.op)
            riaex_pkg::ALU_ADD:
                full_res = i_ctrl.alt ? (i_operand_a - i_operand_b) : (i_operand_a + i_operand_b);
            riaex_pkg::ALU_SLL:  full_res = i_operand_a << sh;
            riaex_pkg::ALU_SLT:  full_res = {{(XLEN-1){1'b0}}, lt_s};
            riaex_pkg::ALU_SLTU: full_res = {{(XLEN-1){1'b0}}, lt_u};
            riaex_pkg::ALU_XOR:  full_res = i_operand_a ^ i_operand_b;
            riaex_pkg::ALU_SRL:
                full_res = i_ctrl.alt ? XLEN'($signed(i_operand_a) >>> sh) : (i_operand_a >> sh);
            riaex_pkg::ALU_OR:   full_res = i_operand_a | i_operand_b;
            default:             full_res = i_operand_a & i_operand_b;
        endcase
    end

    always_comb begin
        case (i_ctrl.op)
            riaex_pkg::ALU_ADD: word_res = i_ctrl.alt ? (a32 - b32) : (a32 + b32);
            riaex_pkg::ALU_SLL: word_res = a32 << wsh;
            riaex_pkg::ALU_SRL: word_res = i_ctrl.alt ? 32'($signed(a32) >>> wsh) : (a32 >> wsh);
            default:            word_res = '0;
        endcase
    end

    assign word_ext = {{32{word_res[31]}}, word_res};

    always_comb begin
        if (!i_ctrl.legal) begin
            o_result = '0;
        end else if (i_ctrl.word) begin
            o_result = word_ext[XLEN-1:0];
        end else begin
            o_result = full_res;
        end
    end

endmodule

`default_nettype wire
